>>> src/gaps_pkg.sv
// Shared types, constants and codes for the grid path search block.
package gaps_pkg;

    localparam int CRD_W          = 3;
    localparam int COST_W         = 10;
    localparam int DIR_W          = 2;
    localparam int GRID_SIDE_DEF  = 8;
    localparam int STEP_COST_DEF  = 10;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_WAYPOINT = 2'd0,
        ST_ARRIVED  = 2'd1,
        ST_NO_PATH  = 2'd2
    } t_status;

    typedef struct packed {
        logic             kind;
        logic [CRD_W-1:0] cell_x;
        logic [CRD_W-1:0] cell_y;
        logic             blocked;
        logic [CRD_W-1:0] target_x;
        logic [CRD_W-1:0] target_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [CRD_W-1:0] step_x;
        logic [CRD_W-1:0] step_y;
        logic             last;
    } t_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    init;
        logic    scan_start;
        logic    close_best;
        logic    nb_issue;
        logic    nb_update;
        logic    trace_start;
        logic    trace_issue;
        logic    trace_step;
        logic    out_issue;
        logic    emit;
        t_status emit_code;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic in_write;
        logic in_same;
        logic in_outside;
        logic scan_busy;
        logic have_best;
        logic best_is_target;
        logic nb_last;
        logic at_start;
        logic out_free;
        logic out_last;
    } t_stat;

endpackage

>>> src/gaps_in_if.sv
// Input channel interface: valid, ready and one request item.
interface gaps_in_if;
    logic                valid;
    logic                ready;
    gaps_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/gaps_out_if.sv
// Output channel interface: valid, ready and one result item.
interface gaps_out_if;
    logic                valid;
    logic                ready;
    gaps_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/gaps_ctrl.sv
// Search sequencer: state machine that drives the datapath by commands.
module gaps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gaps_pkg::t_stat  i_stat,
    output gaps_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SCAN_GO, S_SCAN_WAIT, S_PICK, S_NB_ISSUE, S_NB_UPD,
        S_TRACE_START, S_TRACE_ISSUE, S_TRACE_STEP, S_OUT_ISSUE, S_OUT_EMIT,
        S_EMIT_ARR, S_EMIT_NONE
    } t_state;

    t_state r_state;

    assign o_in_ready = (r_state == S_IDLE);

    // decode commands from the current state
    always_comb begin
        o_cmd           = '0;
        o_cmd.emit_code = gaps_pkg::ST_WAYPOINT;
        unique case (r_state)
            S_IDLE:        o_cmd.load        = i_in_valid;
            S_INIT:        o_cmd.init        = 1'b1;
            S_SCAN_GO:     o_cmd.scan_start  = 1'b1;
            S_SCAN_WAIT:   ;
            S_PICK:        o_cmd.close_best  = i_stat.have_best & ~i_stat.best_is_target;
            S_NB_ISSUE:    o_cmd.nb_issue    = 1'b1;
            S_NB_UPD:      o_cmd.nb_update   = 1'b1;
            S_TRACE_START: o_cmd.trace_start = 1'b1;
            S_TRACE_ISSUE: o_cmd.trace_issue = 1'b1;
            S_TRACE_STEP:  o_cmd.trace_step  = 1'b1;
            S_OUT_ISSUE:   o_cmd.out_issue   = 1'b1;
            S_OUT_EMIT:    o_cmd.emit        = i_stat.out_free;
            S_EMIT_ARR: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_code = gaps_pkg::ST_ARRIVED;
            end
            S_EMIT_NONE: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_code = gaps_pkg::ST_NO_PATH;
            end
            default:       ;
        endcase
    end

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !i_stat.in_write) begin
                        if (i_stat.in_same)         r_state <= S_EMIT_ARR;
                        else if (i_stat.in_outside) r_state <= S_EMIT_NONE;
                        else                        r_state <= S_INIT;
                    end
                end
                S_INIT:      r_state <= S_SCAN_GO;
                S_SCAN_GO:   r_state <= S_SCAN_WAIT;
                S_SCAN_WAIT: if (!i_stat.scan_busy) r_state <= S_PICK;
                S_PICK: begin
                    if (!i_stat.have_best)          r_state <= S_EMIT_NONE;
                    else if (i_stat.best_is_target) r_state <= S_TRACE_START;
                    else                            r_state <= S_NB_ISSUE;
                end
                S_NB_ISSUE:    r_state <= S_NB_UPD;
                S_NB_UPD:      r_state <= i_stat.nb_last ? S_SCAN_GO : S_NB_ISSUE;
                S_TRACE_START: r_state <= S_TRACE_ISSUE;
                S_TRACE_ISSUE: r_state <= i_stat.at_start ? S_OUT_ISSUE : S_TRACE_STEP;
                S_TRACE_STEP:  r_state <= S_TRACE_ISSUE;
                S_OUT_ISSUE:   r_state <= S_OUT_EMIT;
                S_OUT_EMIT: begin
                    if (i_stat.out_free) r_state <= i_stat.out_last ? S_IDLE : S_OUT_ISSUE;
                end
                S_EMIT_ARR:  if (i_stat.out_free) r_state <= S_IDLE;
                S_EMIT_NONE: if (i_stat.out_free) r_state <= S_IDLE;
                default:     r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/gaps_dp.sv
// Search datapath: obstacle map, open/reached sets, cost and route memories.
module gaps_dp #(
    parameter int GRID_SIDE = gaps_pkg::GRID_SIDE_DEF,
    parameter int STEP_COST = gaps_pkg::STEP_COST_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gaps_pkg::t_in_item  i_in_data,
    input  gaps_pkg::t_cmd      i_cmd,
    output gaps_pkg::t_stat     o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output gaps_pkg::t_out_item o_out_data
);

    localparam int CW     = gaps_pkg::CRD_W;
    localparam int KW     = gaps_pkg::COST_W;
    localparam int DW     = gaps_pkg::DIR_W;
    localparam int NCELL  = GRID_SIDE * GRID_SIDE;
    localparam int IW     = $clog2(NCELL);
    localparam logic [CW-1:0] EDGE  = CW'(GRID_SIDE - 1);
    localparam logic [KW-1:0] STEPK = KW'(STEP_COST);

    function automatic logic [IW-1:0] cell_idx(input logic [CW-1:0] x, input logic [CW-1:0] y);
        cell_idx = IW'(int'(y) * GRID_SIDE + int'(x));
    endfunction

    function automatic logic [CW-1:0] adiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        adiff = (a > b) ? a - b : b - a;
    endfunction

    // request registers
    logic [CW-1:0] r_sx, r_sy, r_tx, r_ty;
    // cell flags
    logic [NCELL-1:0] r_blk, r_reached, r_open;
    // memories
    logic [KW-1:0]     cost_mem  [NCELL];
    logic [DW-1:0]     dir_mem   [NCELL];
    logic [2*CW-1:0]   route_mem [NCELL];
    logic [KW-1:0]     r_cost_q;
    logic [DW-1:0]     r_dir_q;
    logic [2*CW-1:0]   r_route_q;
    // scan pipeline
    logic              r_scan_on, r_p_v, r_p_open;
    logic [CW-1:0]     r_cx, r_cy, r_p_x, r_p_y;
    logic              r_have;
    logic [KW:0]       r_bestf;
    logic [CW-1:0]     r_bx, r_by;
    logic [KW-1:0]     r_bg;
    // neighbour update
    logic [DW-1:0]     r_dir;
    logic              r_nv;
    logic [IW-1:0]     r_nidx;
    // trace and output
    logic [CW-1:0]     r_ux, r_uy;
    logic [IW-1:0]     r_cnt, r_oidx;
    logic              r_o_valid;
    gaps_pkg::t_out_item r_o_data;

    logic              in_inside;
    logic [IW-1:0]     in_idx, start_idx, scan_idx, nb_idx, rd_idx, trace_idx;
    logic [KW-1:0]     h_p;
    logic [KW:0]       f_p;
    logic              nv;
    logic [CW-1:0]     nx, ny;
    logic [KW-1:0]     t_cost;
    logic              upd;
    logic              out_free;

    assign in_inside = (int'(i_in_data.cell_x) < GRID_SIDE) && (int'(i_in_data.cell_y) < GRID_SIDE);
    assign in_idx    = cell_idx(i_in_data.cell_x, i_in_data.cell_y);
    assign start_idx = cell_idx(r_sx, r_sy);
    assign scan_idx  = cell_idx(r_cx, r_cy);
    assign trace_idx = cell_idx(r_ux, r_uy);

    // f of the cell whose cost comes back this cycle
    assign h_p = STEPK * KW'({1'b0, adiff(r_p_x, r_tx)} + {1'b0, adiff(r_p_y, r_ty)});
    assign f_p = {1'b0, r_cost_q} + {1'b0, h_p};

    // neighbour of the expanded cell in the current direction
    always_comb begin
        nx = r_bx;
        ny = r_by;
        nv = 1'b0;
        case (r_dir)
            2'd0: begin nv = (r_by != '0);   ny = r_by - 1'b1; end
            2'd1: begin nv = (r_by != EDGE); ny = r_by + 1'b1; end
            2'd2: begin nv = (r_bx != '0);   nx = r_bx - 1'b1; end
            default: begin nv = (r_bx != EDGE); nx = r_bx + 1'b1; end
        endcase
    end
    assign nb_idx = nv ? cell_idx(nx, ny) : '0;
    assign rd_idx = r_scan_on ? scan_idx : nb_idx;

    assign t_cost = r_bg + STEPK;
    assign upd    = r_nv && (!r_reached[r_nidx] || (t_cost < r_cost_q));

    assign out_free = !r_o_valid || i_out_ready;

    // status to controller
    always_comb begin
        o_stat.in_write       = (i_in_data.kind == gaps_pkg::KIND_WRITE);
        o_stat.in_same        = (i_in_data.cell_x == i_in_data.target_x) &&
                                (i_in_data.cell_y == i_in_data.target_y);
        o_stat.in_outside     = !in_inside || (int'(i_in_data.target_x) >= GRID_SIDE) ||
                                (int'(i_in_data.target_y) >= GRID_SIDE);
        o_stat.scan_busy      = r_scan_on || r_p_v;
        o_stat.have_best      = r_have;
        o_stat.best_is_target = (r_bx == r_tx) && (r_by == r_ty);
        o_stat.nb_last        = (r_dir == DW'(3));
        o_stat.at_start       = (r_ux == r_sx) && (r_uy == r_sy);
        o_stat.out_free       = out_free;
        o_stat.out_last       = (r_oidx == '0);
    end

    // map and set flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk     <= '0;
            r_reached <= '0;
            r_open    <= '0;
        end else begin
            if (i_cmd.load && o_stat.in_write && in_inside) begin
                r_blk[in_idx] <= i_in_data.blocked;
            end
            if (i_cmd.init) begin
                // clear both sets, leaving only the start cell
                r_reached <= NCELL'(1) << start_idx;
                r_open    <= NCELL'(1) << start_idx;
            end
            if (i_cmd.close_best) begin
                r_open[cell_idx(r_bx, r_by)] <= 1'b0;
            end
            if (i_cmd.nb_update && upd) begin
                r_reached[r_nidx] <= 1'b1;
                r_open[r_nidx]    <= 1'b1;
            end
        end
    end

    // cost and direction memories
    always_ff @(posedge i_clk) begin
        r_cost_q <= cost_mem[rd_idx];
        if (i_cmd.init) begin
            cost_mem[start_idx] <= '0;
        end else if (i_cmd.nb_update && upd) begin
            cost_mem[r_nidx] <= t_cost;
        end
        if (i_cmd.nb_update && upd) begin
            dir_mem[r_nidx] <= r_dir;
        end
        if (i_cmd.trace_issue) begin
            r_dir_q <= dir_mem[trace_idx];
        end
    end

    // route memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.trace_issue && !o_stat.at_start) begin
            route_mem[r_cnt] <= {r_uy, r_ux};
        end
        if (i_cmd.out_issue) begin
            r_route_q <= route_mem[r_oidx];
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_p_v     <= 1'b0;
            r_have    <= 1'b0;
        end else begin
            r_p_v <= r_scan_on;
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
                r_have    <= 1'b0;
            end else if (r_scan_on && (r_cx == EDGE) && (r_cy == EDGE)) begin
                r_scan_on <= 1'b0;
            end
            if (r_p_v && r_p_open && (!r_have || (f_p < r_bestf))) begin
                r_have <= 1'b1;
            end
        end
    end

    // scan datapath: walk cells in index order, keep the first lowest f
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (r_scan_on) begin
            if (r_cx == EDGE) begin
                r_cx <= '0;
                r_cy <= r_cy + 1'b1;
            end else begin
                r_cx <= r_cx + 1'b1;
            end
        end
        r_p_x    <= r_cx;
        r_p_y    <= r_cy;
        r_p_open <= r_open[scan_idx];
        if (r_p_v && r_p_open && (!r_have || (f_p < r_bestf))) begin
            r_bestf <= f_p;
            r_bx    <= r_p_x;
            r_by    <= r_p_y;
            r_bg    <= r_cost_q;
        end
    end

    // request, neighbour, trace and output index registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx <= i_in_data.cell_x;
            r_sy <= i_in_data.cell_y;
            r_tx <= i_in_data.target_x;
            r_ty <= i_in_data.target_y;
        end
        if (i_cmd.close_best) begin
            r_dir <= '0;
        end else if (i_cmd.nb_update) begin
            r_dir <= r_dir + 1'b1;
        end
        if (i_cmd.nb_issue) begin
            r_nv   <= nv && !r_blk[nb_idx];
            r_nidx <= nb_idx;
        end
        if (i_cmd.trace_start) begin
            r_ux  <= r_tx;
            r_uy  <= r_ty;
            r_cnt <= '0;
        end else if (i_cmd.trace_issue) begin
            if (o_stat.at_start) begin
                r_oidx <= r_cnt - 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (i_cmd.trace_step) begin
            // step back against the direction of arrival
            case (r_dir_q)
                2'd0:    r_uy <= r_uy + 1'b1;
                2'd1:    r_uy <= r_uy - 1'b1;
                2'd2:    r_ux <= r_ux + 1'b1;
                default: r_ux <= r_ux - 1'b1;
            endcase
        end
        if (i_cmd.emit && (i_cmd.emit_code == gaps_pkg::ST_WAYPOINT)) begin
            r_oidx <= r_oidx - 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_data.status <= i_cmd.emit_code;
            case (i_cmd.emit_code)
                gaps_pkg::ST_WAYPOINT: begin
                    r_o_data.step_x <= r_route_q[CW-1:0];
                    r_o_data.step_y <= r_route_q[2*CW-1:CW];
                    r_o_data.last   <= (r_oidx == '0);
                end
                gaps_pkg::ST_ARRIVED: begin
                    r_o_data.step_x <= r_tx;
                    r_o_data.step_y <= r_ty;
                    r_o_data.last   <= 1'b1;
                end
                default: begin
                    r_o_data.step_x <= '0;
                    r_o_data.step_y <= '0;
                    r_o_data.last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

>>> src/grid_astar_path_search_core.sv
// Top level of the grid A* path search block.
// Usage:
//   i_in carries one request per transfer. kind = write stores the blocked
//   bit of one map cell and gives no result. kind = search runs A* with
//   four-way moves from (cell_x, cell_y) to (target_x, target_y).
//   o_out carries results: the waypoints from the first step to the target,
//   last set on the target; or one result with status already-at-target or
//   no-path, last set.
// Operation:
//   A search first sets up, then for each expanded cell scans the whole
//   open set over all GRID_SIDE^2 cells and updates the four neighbours;
//   the path is then traced back from the target and the waypoints are
//   output one by one. The scan over the single read port of the cost
//   memory sets the rate. One item is worked on at a time.
// Reset: the obstacle map reads all free, the output register is empty.
// Stall: results wait in the output register; the search holds until the
//   register is taken, and the next request is taken while the last result
//   still waits.
module grid_astar_path_search_core #(
    parameter int GRID_SIDE = gaps_pkg::GRID_SIDE_DEF,
    parameter int STEP_COST = gaps_pkg::STEP_COST_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    gaps_in_if.sink    i_in,
    gaps_out_if.source o_out
);

    gaps_pkg::t_cmd  cmd;
    gaps_pkg::t_stat stat;

    gaps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gaps_dp #(
        .GRID_SIDE (GRID_SIDE),
        .STEP_COST (STEP_COST)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );

endmodule
